>>> sv/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the packed pixel unpacker: depth codes,
// register map, dimension limits and the structs passed between blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

	// Dimension limits
	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
	localparam int unsigned DIM_W      = 13;

	// Source depth codes (code 3 runs as 4 bpp)
	localparam logic [1:0] MODE_1BPP = 2'd0;
	localparam logic [1:0] MODE_2BPP = 2'd1;
	localparam logic [1:0] MODE_4BPP = 2'd2;

	// Register map, word index on paddr[3:2]
	localparam int unsigned APB_AW = 4;
	localparam logic [1:0] REG_BITS_MODE    = 2'd0;
	localparam logic [1:0] REG_NORMALIZE    = 2'd1;
	localparam logic [1:0] REG_ROW_WIDTH    = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	// Byte queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Working configuration seen by the back end
	typedef struct packed {
		logic [1:0]       mode;
		logic             normalize;
		logic [COL_W-1:0] last_col;
		logic [ROW_W-1:0] last_row;
	} cfg_t;

	// Head of the byte queue
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} head_t;

endpackage

`default_nettype wire

>>> sv/ppu_in_if.sv
// ----------------------------------------------------------------------------
// ppu_in_if
// Packed byte channel: valid/ready handshake with one source byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;

	modport source (output valid, output packed_byte, input ready);
	modport sink   (input valid, input packed_byte, output ready);
endinterface

`default_nettype wire

>>> sv/ppu_out_if.sv
// ----------------------------------------------------------------------------
// ppu_out_if
// Pixel channel: valid/ready handshake with one unpacked pixel and its
// byte, row and image flags per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       last_of_byte;
	logic       end_of_row;
	logic       end_of_image;

	modport source (output valid, output pixel_value, output last_of_byte,
		output end_of_row, output end_of_image, input ready);
	modport sink   (input valid, input pixel_value, input last_of_byte,
		input end_of_row, input end_of_image, output ready);
endinterface

`default_nettype wire

>>> sv/ppu_regs.sv
// ----------------------------------------------------------------------------
// ppu_regs
// APB register file. Holds the four configuration registers and derives the
// clamped last column and last row indexes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ppu_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output ppu_pkg::cfg_t                   cfg
);
	import ppu_pkg::*;

	logic [1:0]       bits_mode_q;
	logic             normalize_q;
	logic [DIM_W-1:0] row_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [1:0]       idx;
	logic             wr_en;
	logic [DIM_W-1:0] width_m1;
	logic [DIM_W-1:0] height_m1;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_mode_q    <= MODE_1BPP;
			normalize_q    <= 1'b1;
			row_width_q    <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_BITS_MODE:    bits_mode_q    <= pwdata[1:0];
				REG_NORMALIZE:    normalize_q    <= pwdata[0];
				REG_ROW_WIDTH:    row_width_q    <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_BITS_MODE:    prdata = {30'd0, bits_mode_q};
			REG_NORMALIZE:    prdata = {31'd0, normalize_q};
			REG_ROW_WIDTH:    prdata = {{(32-DIM_W){1'b0}}, row_width_q};
			REG_IMAGE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, image_height_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Clamp dimensions: zero acts as one, oversize saturates to the limit
	assign width_m1  = row_width_q - DIM_W'(1);
	assign height_m1 = image_height_q - DIM_W'(1);

	always_comb begin
		cfg.mode      = bits_mode_q;
		cfg.normalize = normalize_q;
		if (row_width_q == '0)
			cfg.last_col = '0;
		else if (row_width_q > DIM_W'(MAX_WIDTH))
			cfg.last_col = COL_W'(MAX_WIDTH - 1);
		else
			cfg.last_col = width_m1[COL_W-1:0];
		if (image_height_q == '0)
			cfg.last_row = '0;
		else if (image_height_q > DIM_W'(MAX_HEIGHT))
			cfg.last_row = ROW_W'(MAX_HEIGHT - 1);
		else
			cfg.last_row = height_m1[ROW_W-1:0];
	end

endmodule

`default_nettype wire

>>> sv/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front
// Front end: accepts packed source bytes and queues them for the back end.
// Ready depends only on the fill level, so it has no combinational path from the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ppu_in_if.sink       byte_in,
	input  wire logic    pop,
	output ppu_pkg::head_t head
);
	import ppu_pkg::*;

	logic [7:0]        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop_ok;

	assign byte_in.ready = (count_q != QCNT_W'(QDEPTH));
	assign push          = byte_in.valid && byte_in.ready;
	assign pop_ok        = pop && (count_q != '0);
	assign head.valid    = (count_q != '0);
	assign head.data     = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= byte_in.packed_byte;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop_ok)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop_ok})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/ppu_back.sv
// ----------------------------------------------------------------------------
// ppu_back
// Back end: unpacks the byte one pixel per cycle unless stalled, expands it,
// tracks column and row position and drives the registered pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ppu_pkg::cfg_t  cfg,
	input  wire ppu_pkg::head_t head,
	output logic               pop,
	ppu_out_if.source          pixel_out
);
	import ppu_pkg::*;

	logic             cur_valid_q;
	logic [7:0]       cur_byte_q;
	logic [2:0]       pix_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             out_valid_q;
	logic [7:0]       out_pix_q;
	logic             out_lob_q;
	logic             out_eor_q;
	logic             out_eoi_q;

	logic       out_can;
	logic       adv;
	logic [3:0] raw;
	logic [7:0] value;
	logic [2:0] last_idx;
	logic [7:0] next_byte;
	logic       eor;
	logic       eoi;
	logic       last_pix;

	assign out_can = !out_valid_q || pixel_out.ready;
	assign adv     = cur_valid_q && out_can;

	// Pixel select and expansion by depth
	always_comb begin
		case (cfg.mode)
			MODE_1BPP: begin
				raw       = {3'd0, cur_byte_q[7]};
				last_idx  = 3'd7;
				next_byte = {cur_byte_q[6:0], 1'b0};
				value     = cfg.normalize ? {8{cur_byte_q[7]}} : {7'd0, cur_byte_q[7]};
			end
			MODE_2BPP: begin
				raw       = {2'd0, cur_byte_q[7:6]};
				last_idx  = 3'd3;
				next_byte = {cur_byte_q[5:0], 2'b00};
				value     = cfg.normalize ? {4{cur_byte_q[7:6]}} : {6'd0, cur_byte_q[7:6]};
			end
			default: begin
				raw       = cur_byte_q[7:4];
				last_idx  = 3'd1;
				next_byte = {cur_byte_q[3:0], 4'd0};
				value     = cfg.normalize ? {raw, raw} : {4'd0, raw};
			end
		endcase
	end

	// Position flags
	assign eor      = (col_q >= cfg.last_col);
	assign eoi      = eor && (row_q >= cfg.last_row);
	assign last_pix = eor || (pix_q == last_idx);
	assign pop      = out_can && (!cur_valid_q || last_pix);

	// Current byte and pixel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pix_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= head.valid;
			pix_q       <= '0;
		end else if (adv) begin
			pix_q <= pix_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_byte_q <= head.data;
		else if (adv)
			cur_byte_q <= next_byte;
	end

	// Column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (eor) begin
				col_q <= '0;
				row_q <= eoi ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_can)
			out_valid_q <= cur_valid_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix_q <= value;
			out_lob_q <= last_pix;
			out_eor_q <= eor;
			out_eoi_q <= eoi;
		end
	end

	assign pixel_out.valid        = out_valid_q;
	assign pixel_out.pixel_value  = out_pix_q;
	assign pixel_out.last_of_byte = out_lob_q;
	assign pixel_out.end_of_row   = out_eor_q;
	assign pixel_out.end_of_image = out_eoi_q;

endmodule

`default_nettype wire

>>> sv/packed_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// packed_pixel_unpacker
// Unpacks 1, 2 or 4 bpp source bytes, first pixel in the high bits, into
// 8-bit pixels with byte, row and image end flags.
//
//   channel     role   beat payload
//   byte_in     sink   packed_byte
//   pixel_out   source pixel_value, last_of_byte, end_of_row, end_of_image
//   APB         slave  bits_mode, normalize, row_width, image_height
//
// One pixel leaves per cycle while pixel_out is ready; a byte gives 8, 4 or 2
// pixels at 1, 2 or 4 bpp, fewer when a row ends inside it. The back end
// counts the pixels of each byte. A two-byte queue parts input from unpacking,
// and the pixel output is registered. Reset clears counters and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_unpacker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ppu_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	ppu_in_if.sink                          byte_in,
	ppu_out_if.source                       pixel_out
);
	import ppu_pkg::*;

	cfg_t  cfg;
	head_t head;
	logic  pop;

	ppu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.pop     (pop),
		.head    (head)
	);

	ppu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.pop       (pop),
		.pixel_out (pixel_out)
	);

endmodule

`default_nettype wire
